>>> sv/rsd_pkg.sv
// Shared constants and engine handshake types for the running standard deviation block.
`timescale 1ns / 1ps

package rsd_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int STDEV_W         = 32;
    localparam int FRAC_SHIFT      = 16;
    localparam int ROOT_STEPS      = 32;
    localparam int MIN_COUNT       = 2;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef struct packed {
        logic start;
        logic pop_mode;
    } eng_req_t;

    typedef struct packed {
        logic                 done;
        logic [STDEV_W-1:0]   stdev;
    } eng_rsp_t;

endpackage

>>> sv/rsd_engine.sv
// Finish engine: multiplies, subtracts, divides and takes the root on one shared adder.
`timescale 1ns / 1ps

module rsd_engine #(
    parameter int SAMPLE_BITS = rsd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rsd_pkg::COUNT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rsd_pkg::eng_req_t                     req,
    input  logic [SAMPLE_BITS+COUNT_BITS-1:0]     sum_i,
    input  logic [2*SAMPLE_BITS+COUNT_BITS-3:0]   sumsq_i,
    input  logic [COUNT_BITS-1:0]                 count_i,
    output rsd_pkg::eng_rsp_t                     rsp
);

    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int MAG_W  = SUM_W - 1;
    localparam int PROD_W = 2 * SAMPLE_BITS + 2 * COUNT_BITS - 2;
    localparam int NUM_W  = PROD_W + rsd_pkg::FRAC_SHIFT;
    localparam int D_W    = 2 * COUNT_BITS;
    localparam int WK_W   = (NUM_W > 64) ? NUM_W : 64;
    localparam int QX_W   = (WK_W > 64) ? WK_W : 65;
    localparam int ALU_W  = (PROD_W > 34) ? PROD_W : 34;
    localparam int CNT_W  = $clog2(WK_W + 1);
    localparam int RT_W   = rsd_pkg::STDEV_W;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MULA = 8'b0000_0010,
        ST_MULB = 8'b0000_0100,
        ST_SUB  = 8'b0000_1000,
        ST_MULD = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_SQRT = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } eng_state_t;

    eng_state_t         state_reg;
    logic [ALU_W-1:0]   acc_reg;
    logic [ALU_W-1:0]   mcand_reg;
    logic [MAG_W-1:0]   mplr_reg;
    logic [PROD_W-1:0]  prod_a_reg;
    logic [WK_W-1:0]    work_reg;
    logic [RT_W-1:0]    root_reg;
    logic [MAG_W-1:0]   sum_mag_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic               pop_reg;
    logic               sat_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic               alu_sub;
    logic [ALU_W:0]     alu_sum;
    logic [ALU_W-1:0]   alu_res;
    logic               alu_carry;

    logic [SUM_W-1:0]   sum_neg;
    logic [MAG_W-1:0]   sum_mag;
    logic [ALU_W-1:0]   mul_acc_next;
    logic [WK_W-1:0]    div_work_next;
    logic [QX_W-1:0]    quot_ext;
    logic               last_step;

    assign sum_neg = ~sum_i + SUM_W'(1);
    assign sum_mag = sum_i[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_i[MAG_W-1:0];

    // The single adder; in subtract mode the carry out is high when a >= b.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_MULA, ST_MULB, ST_MULD: begin
                alu_a = acc_reg;
                alu_b = mcand_reg;
            end
            ST_SUB: begin
                alu_a   = ALU_W'(prod_a_reg);
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a   = ALU_W'({acc_reg[D_W-1:0], work_reg[WK_W-1]});
                alu_b   = mcand_reg;
                alu_sub = 1'b1;
            end
            ST_SQRT: begin
                alu_a   = ALU_W'({acc_reg[RT_W-1:0], work_reg[63:62]});
                alu_b   = ALU_W'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + (ALU_W+1)'(alu_sub);
    assign alu_res   = alu_sum[ALU_W-1:0];
    assign alu_carry = alu_sum[ALU_W];

    assign mul_acc_next  = mplr_reg[0] ? alu_res : acc_reg;
    assign div_work_next = {work_reg[WK_W-2:0], alu_carry};
    assign quot_ext      = QX_W'(div_work_next);
    assign last_step     = (cnt_reg == CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        state_reg   <= ST_MULA;
                        acc_reg     <= '0;
                        mcand_reg   <= ALU_W'(sumsq_i);
                        mplr_reg    <= MAG_W'(count_i);
                        sum_mag_reg <= sum_mag;
                        n_reg       <= count_i;
                        pop_reg     <= req.pop_mode;
                        cnt_reg     <= CNT_W'(COUNT_BITS);
                    end
                end
                ST_MULA: begin
                    mcand_reg <= mcand_reg << 1;
                    mplr_reg  <= mplr_reg >> 1;
                    acc_reg   <= mul_acc_next;
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    if (last_step) begin
                        state_reg  <= ST_MULB;
                        prod_a_reg <= mul_acc_next[PROD_W-1:0];
                        acc_reg    <= '0;
                        mcand_reg  <= ALU_W'(sum_mag_reg);
                        mplr_reg   <= sum_mag_reg;
                        cnt_reg    <= CNT_W'(MAG_W);
                    end
                end
                ST_MULB: begin
                    mcand_reg <= mcand_reg << 1;
                    mplr_reg  <= mplr_reg >> 1;
                    acc_reg   <= mul_acc_next;
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    if (last_step) begin
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    // A negative difference is clamped to zero before scaling.
                    work_reg  <= WK_W'({(alu_carry ? alu_res[PROD_W-1:0] : {PROD_W{1'b0}}),
                                        {rsd_pkg::FRAC_SHIFT{1'b0}}});
                    state_reg <= ST_MULD;
                    acc_reg   <= '0;
                    mcand_reg <= ALU_W'(n_reg);
                    mplr_reg  <= pop_reg ? MAG_W'(n_reg)
                                         : MAG_W'(n_reg - COUNT_BITS'(1));
                    cnt_reg   <= CNT_W'(COUNT_BITS);
                end
                ST_MULD: begin
                    mcand_reg <= mcand_reg << 1;
                    mplr_reg  <= mplr_reg >> 1;
                    acc_reg   <= mul_acc_next;
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    if (last_step) begin
                        state_reg <= ST_DIV;
                        mcand_reg <= ALU_W'(mul_acc_next[D_W-1:0]);
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(WK_W);
                    end
                end
                ST_DIV: begin
                    acc_reg  <= alu_carry ? alu_res : alu_a;
                    work_reg <= div_work_next;
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (last_step) begin
                        state_reg <= ST_SQRT;
                        sat_reg   <= |quot_ext[QX_W-1:64];
                        acc_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= CNT_W'(rsd_pkg::ROOT_STEPS);
                    end
                end
                ST_SQRT: begin
                    acc_reg  <= alu_carry ? alu_res : alu_a;
                    root_reg <= {root_reg[RT_W-2:0], alu_carry};
                    work_reg <= {work_reg[WK_W-3:0], 2'b00};
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (last_step) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = (state_reg == ST_DONE);
    assign rsp.stdev = sat_reg ? {RT_W{1'b1}} : root_reg;

`ifndef ASSERT_OFF
    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == ST_IDLE)
        else $error("engine started while busy");
    a_done_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |=> state_reg == ST_IDLE)
        else $error("engine done held for more than one cycle");
    a_sqrt_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_SQRT) |-> $past(state_reg) == ST_DIV)
        else $error("root entered without a division");
`endif

endmodule

>>> sv/running_std_deviation.sv
// Running standard deviation: streaming accumulator with an iterative finish engine.
//
// Input channel s_*: s_tuser carries the function (0 adds a sample, 1 finishes) and
// s_tdata the signed sample. Add requests are taken back to back while s_tready is high, even
// while a finished result still waits on the output. The count saturates at its maximum;
// later samples are dropped and a sticky overflow flag is raised.
// A finish request clears the accumulators and produces exactly one result on m_*.
// With fewer than two samples the result is null and goes through the put state to the
// output register once it is free. Otherwise the shared adder of the finish engine runs,
// one bit per cycle, through n*sumsq, sum^2, the subtraction, the divisor, a restoring
// division over max(2*SAMPLE_BITS+2*COUNT_BITS+14, 64) steps and a 32-step square root.
// s_tready stays low from a finish request until its result sits in the output register.
// The output register holds its result while m_tready is low.
// cfg_* writes the population mode bit and is always ready; the user must write it only when idle (not enforced here).
// Reset (aresetn low, synchronous) clears the accumulators, the mode and the output valid flag.
`timescale 1ns / 1ps

module running_std_deviation #(
    parameter int SAMPLE_BITS = rsd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rsd_pkg::COUNT_BITS_DEF,
    localparam int S_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_DATA_W-1:0]         s_tdata,   // sample_value
    input  logic                        s_tuser,   // func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rsd_pkg::STDEV_W-1:0] m_tdata,   // stdev_value
    output logic [1:0]                  m_tuser,   // overflow, result_valid
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data   // population_mode
);

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS - 2;

    typedef enum logic [2:0] {
        TOP_IDLE = 3'b001,
        TOP_CALC = 3'b010,
        TOP_PUT  = 3'b100
    } top_state_t;

    top_state_t                  state_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [SQ_W-1:0]             sumsq_reg;
    logic [COUNT_BITS-1:0]       count_reg;
    logic                        ovf_reg;
    logic                        pop_mode_reg;
    logic                        res_valid_reg;
    logic                        res_ovf_reg;
    logic [rsd_pkg::STDEV_W-1:0] res_stdev_reg;
    logic                        m_tvalid_reg;
    logic [rsd_pkg::STDEV_W-1:0] m_tdata_reg;
    logic [1:0]                  m_tuser_reg;

    logic [SAMPLE_BITS-1:0]      sample;
    logic [SAMPLE_BITS-1:0]      sample_mag;
    logic [2*SAMPLE_BITS-1:0]    sample_sq;
    logic                        in_acc;
    logic                        add_acc;
    logic                        fin_acc;
    logic                        count_full;
    logic                        enough;
    logic                        out_free;
    rsd_pkg::eng_req_t           eng_req;
    rsd_pkg::eng_rsp_t           eng_rsp;

    assign s_tready  = (state_reg == TOP_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign add_acc   = in_acc && (s_tuser == rsd_pkg::FUNC_ADD);
    assign fin_acc   = in_acc && (s_tuser == rsd_pkg::FUNC_FINISH);

    assign sample     = s_tdata[SAMPLE_BITS-1:0];
    assign sample_mag = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
    assign sample_sq  = sample_mag * sample_mag;
    assign count_full = (count_reg == {COUNT_BITS{1'b1}});
    assign enough     = (count_reg >= COUNT_BITS'(rsd_pkg::MIN_COUNT));
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        eng_req.start    = fin_acc && enough;
        eng_req.pop_mode = pop_mode_reg;
    end

    rsd_engine #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (eng_req),
        .sum_i   (sum_reg),
        .sumsq_i (sumsq_reg),
        .count_i (count_reg),
        .rsp     (eng_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            pop_mode_reg <= cfg_data;
        end
    end

    // Accumulators; the engine takes its snapshot on the cycle they are cleared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (fin_acc) begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (add_acc) begin
            if (count_full) begin
                ovf_reg <= 1'b1;
            end else begin
                sum_reg   <= sum_reg + {{COUNT_BITS{sample[SAMPLE_BITS-1]}}, sample};
                sumsq_reg <= sumsq_reg + SQ_W'(sample_sq);
                count_reg <= count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= TOP_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In the put state the output register is reloaded instead.
            if (m_tvalid_reg && m_tready && (state_reg != TOP_PUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                TOP_IDLE: begin
                    if (fin_acc) begin
                        res_ovf_reg   <= ovf_reg;
                        res_valid_reg <= enough;
                        res_stdev_reg <= '0;
                        state_reg     <= enough ? TOP_CALC : TOP_PUT;
                    end
                end
                TOP_CALC: begin
                    if (eng_rsp.done) begin
                        res_stdev_reg <= eng_rsp.stdev;
                        state_reg     <= TOP_PUT;
                    end
                end
                TOP_PUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_stdev_reg;
                        m_tuser_reg  <= {res_ovf_reg, res_valid_reg};
                        state_reg    <= TOP_IDLE;
                    end
                end
                default: begin
                    state_reg <= TOP_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_clear_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_acc |=> count_reg == '0 && sum_reg == '0 && !ovf_reg)
        else $error("accumulators not cleared after a finish request");
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !fin_acc |=> count_reg >= $past(count_reg))
        else $error("sample count went down without a finish request");
    a_null_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("null result carries a non-zero deviation");
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_rsp.done |-> state_reg == TOP_CALC)
        else $error("engine result arrived with no finish pending");
    a_short_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_acc && !enough |=> state_reg == TOP_PUT && !res_valid_reg)
        else $error("finish with too few samples did not give a null result");
`endif

endmodule
